>>> design/gdd_pkg.sv
package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DNUM_W  = 23;
    localparam int DIST_W  = 22;
    localparam int STAGES  = 6;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [DNUM_W-1:0]  dnum_t;
    typedef logic [DIST_W-1:0]  dist_t;

    typedef struct packed {
        logic s6;
        logic s5;
        logic s4;
        logic s3;
        logic s2;
        logic s1;
    } pipe_en_t;

    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [4:0]  DIV25         = 5'd25;
    localparam logic [10:0] RECIP25       = 11'd1310;
    localparam int          RECIP_SHIFT   = 15;
    localparam month_t      MONTH_MAR     = 4'd3;
    localparam dist_t       DIST_MAX      = {DIST_W{1'b1}};

    function automatic logic [8:0] days_before_month(input month_t m);
        logic [8:0] r;
        case (m)
            4'd0, 4'd1: r = 9'd0;
            4'd2:       r = 9'd31;
            4'd3:       r = 9'd59;
            4'd4:       r = 9'd90;
            4'd5:       r = 9'd120;
            4'd6:       r = 9'd151;
            4'd7:       r = 9'd181;
            4'd8:       r = 9'd212;
            4'd9:       r = 9'd243;
            4'd10:      r = 9'd273;
            4'd11:      r = 9'd304;
            default:    r = 9'd334;
        endcase
        return r;
    endfunction

endpackage

>>> design/gdd_in_if.sv
interface gdd_in_if;
    import gdd_pkg::*;

    logic   valid;
    logic   ready;
    year_t  year_a;
    month_t month_a;
    day_t   day_a;
    year_t  year_b;
    month_t month_b;
    day_t   day_b;

    modport source (
        output valid, year_a, month_a, day_a, year_b, month_b, day_b,
        input  ready
    );

    modport sink (
        input  valid, year_a, month_a, day_a, year_b, month_b, day_b,
        output ready
    );
endinterface

>>> design/gdd_out_if.sv
interface gdd_out_if;
    import gdd_pkg::*;

    logic  valid;
    logic  ready;
    dist_t day_distance;
    logic  first_is_later;

    modport source (
        output valid, day_distance, first_is_later,
        input  ready
    );

    modport sink (
        input  valid, day_distance, first_is_later,
        output ready
    );
endinterface

>>> design/gdd_day_number.sv
module gdd_day_number (
    input  logic              clk,
    input  gdd_pkg::pipe_en_t en,
    input  gdd_pkg::year_t    year,
    input  gdd_pkg::month_t   month,
    input  gdd_pkg::day_t     day,
    output gdd_pkg::dnum_t    day_num
);
    import gdd_pkg::*;

    // stage 1: reciprocal products and 365 * year
    year_t         y_s1_reg;
    month_t        m_s1_reg;
    day_t          d_s1_reg;
    dnum_t         y365_s1_reg;
    logic [22:0]   p100_s1_reg;
    logic [20:0]   p400_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            y_s1_reg    <= year;
            m_s1_reg    <= month;
            d_s1_reg    <= day;
            y365_s1_reg <= DNUM_W'(year) * DNUM_W'(DAYS_PER_YEAR);
            p100_s1_reg <= 23'(year[YEAR_W-1:2]) * 23'(RECIP25);
            p400_s1_reg <= 21'(year[YEAR_W-1:4]) * 21'(RECIP25);
        end
    end

    // stage 2: correct quotients by 25
    logic [7:0]  q100_raw;
    logic [11:0] t100;
    logic [5:0]  q400_raw;
    logic [9:0]  t400;
    logic [7:0]  q100_next;
    logic        nz100_next;
    logic [5:0]  q400_next;
    logic        nz400_next;

    always_comb
    begin
        q100_raw = p100_s1_reg[22:RECIP_SHIFT];
        t100     = y_s1_reg[YEAR_W-1:2] - 12'(12'(q100_raw) * 12'(DIV25));
        if (t100 >= 12'(DIV25))
        begin
            q100_next  = q100_raw + 8'd1;
            nz100_next = (t100 != 12'(DIV25));
        end
        else
        begin
            q100_next  = q100_raw;
            nz100_next = (t100 != 12'd0);
        end

        q400_raw = p400_s1_reg[20:RECIP_SHIFT];
        t400     = y_s1_reg[YEAR_W-1:4] - 10'(10'(q400_raw) * 10'(DIV25));
        if (t400 >= 10'(DIV25))
        begin
            q400_next  = q400_raw + 6'd1;
            nz400_next = (t400 != 10'(DIV25));
        end
        else
        begin
            q400_next  = q400_raw;
            nz400_next = (t400 != 10'd0);
        end
    end

    year_t      y_s2_reg;
    month_t     m_s2_reg;
    day_t       d_s2_reg;
    dnum_t      y365_s2_reg;
    logic [7:0] q100_reg;
    logic       nz100_reg;
    logic [5:0] q400_reg;
    logic       nz400_reg;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            y_s2_reg    <= y_s1_reg;
            m_s2_reg    <= m_s1_reg;
            d_s2_reg    <= d_s1_reg;
            y365_s2_reg <= y365_s1_reg;
            q100_reg    <= q100_next;
            nz100_reg   <= nz100_next;
            q400_reg    <= q400_next;
            nz400_reg   <= nz400_next;
        end
    end

    // stage 3: days in whole years before this one, leap flag
    logic        y4z;
    logic        y16z;
    logic [12:0] ceil4;
    logic [8:0]  ceil100;
    logic [6:0]  ceil400;
    dnum_t       base_next;
    logic        leap_next;

    always_comb
    begin
        y4z       = (y_s2_reg[1:0] == 2'd0);
        y16z      = (y_s2_reg[3:0] == 4'd0);
        ceil4     = 13'(y_s2_reg[YEAR_W-1:2]) + 13'(!y4z);
        ceil100   = 9'(q100_reg) + 9'(!y4z || nz100_reg);
        ceil400   = 7'(q400_reg) + 7'(!y16z || nz400_reg);
        base_next = y365_s2_reg + DNUM_W'(ceil4) - DNUM_W'(ceil100) + DNUM_W'(ceil400);
        leap_next = (y4z && nz100_reg) || (y16z && !nz400_reg);
    end

    month_t m_s3_reg;
    day_t   d_s3_reg;
    dnum_t  base_reg;
    logic   leap_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            m_s3_reg <= m_s2_reg;
            d_s3_reg <= d_s2_reg;
            base_reg <= base_next;
            leap_reg <= leap_next;
        end
    end

    // stage 4: add month and day
    dnum_t day_num_next;
    dnum_t day_num_reg;

    always_comb
    begin
        day_num_next = base_reg + DNUM_W'(days_before_month(m_s3_reg))
                     + DNUM_W'(leap_reg && (m_s3_reg >= MONTH_MAR))
                     + DNUM_W'(d_s3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            day_num_reg <= day_num_next;
        end
    end

    assign day_num = day_num_reg;

endmodule

>>> design/gdd_diff.sv
module gdd_diff (
    input  logic              clk,
    input  gdd_pkg::pipe_en_t en,
    input  gdd_pkg::dnum_t    num_a,
    input  gdd_pkg::dnum_t    num_b,
    output gdd_pkg::dist_t    day_distance,
    output logic              first_is_later
);
    import gdd_pkg::*;

    // stage 5: both differences and ordering
    dnum_t dab_reg;
    dnum_t dba_reg;
    logic  later_s5_reg;

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            dab_reg      <= num_a - num_b;
            dba_reg      <= num_b - num_a;
            later_s5_reg <= (num_a > num_b);
        end
    end

    // stage 6: select magnitude, saturate
    dnum_t mag;
    dist_t dist_next;
    dist_t dist_reg;
    logic  later_reg;

    always_comb
    begin
        mag = later_s5_reg ? dab_reg : dba_reg;
        if (mag[DNUM_W-1])
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = mag[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            dist_reg  <= dist_next;
            later_reg <= later_s5_reg;
        end
    end

    assign day_distance   = dist_reg;
    assign first_is_later = later_reg;

endmodule

>>> design/gregorian_date_difference.sv
// Days between two proleptic Gregorian dates: six register stages, one date pair
// accepted per cycle while the output is not stalled; the stage count comes from
// the reciprocal multiply and correction that replace division by 100 and 400,
// and each stage holds independently, so bubbles close up under back-pressure.
module gregorian_date_difference (
    input logic       clk,
    input logic       rst_n,
    gdd_in_if.sink    dates,
    gdd_out_if.source result
);
    import gdd_pkg::*;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] en_vec;
    pipe_en_t          en;
    dnum_t             num_a;
    dnum_t             num_b;

    // a stage advances when empty or when the stage after it advances
    always_comb
    begin
        en_vec[STAGES-1] = !v_reg[STAGES-1] || result.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en_vec[k] = !v_reg[k] || en_vec[k+1];
        end
        v_next = v_reg;
        if (en_vec[0])
        begin
            v_next[0] = dates.valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en_vec[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    assign en = pipe_en_t'(en_vec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign dates.ready  = en_vec[0];
    assign result.valid = v_reg[STAGES-1];

    gdd_day_number u_num_a (
        .clk     (clk),
        .en      (en),
        .year    (dates.year_a),
        .month   (dates.month_a),
        .day     (dates.day_a),
        .day_num (num_a)
    );

    gdd_day_number u_num_b (
        .clk     (clk),
        .en      (en),
        .year    (dates.year_b),
        .month   (dates.month_b),
        .day     (dates.day_b),
        .day_num (num_b)
    );

    gdd_diff u_diff (
        .clk            (clk),
        .en             (en),
        .num_a          (num_a),
        .num_b          (num_b),
        .day_distance   (result.day_distance),
        .first_is_later (result.first_is_later)
    );

    a_ready_on_bubble : assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg != {STAGES{1'b1}}) |-> dates.ready)
        else $error("input stalled while pipeline holds a bubble");

    a_transfer_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (dates.valid && dates.ready) |=> v_reg[0])
        else $error("accepted transfer missing from first stage");

    a_later_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.first_is_later) |-> (result.day_distance != '0))
        else $error("later flag set with zero distance");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import gdd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 750;
    localparam int unsigned SETTLE       = 30;

    typedef struct packed {
        year_t  year_a;
        month_t month_a;
        day_t   day_a;
        year_t  year_b;
        month_t month_b;
        day_t   day_b;
    } date_pair_t;

    typedef struct packed {
        dist_t day_distance;
        logic  first_is_later;
    } distance_t;

    class distance_scoreboard;
        distance_t   owed_distances[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned month_days(int unsigned y, int unsigned m);
            case (m)
                2:           return 28 + leap_year(y);
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        static function int unsigned day_count(year_t y, month_t m, day_t d);
            int unsigned yy;
            int unsigned mm;
            int unsigned n;
            yy = y;
            mm = m;
            if (mm == 0)
                mm = 1;
            if (mm > 12)
                mm = 12;
            n = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
            for (int unsigned k = 1; k < mm; k++)
                n += month_days(yy, k);
            return n + d;
        endfunction

        static function distance_t predict_distance(date_pair_t p);
            distance_t   r;
            int unsigned na;
            int unsigned nb;
            int unsigned gap;
            na = day_count(p.year_a, p.month_a, p.day_a);
            nb = day_count(p.year_b, p.month_b, p.day_b);
            r.first_is_later = (na > nb);
            gap = (na > nb) ? na - nb : nb - na;
            r.day_distance = (gap > int'(DIST_MAX)) ? DIST_MAX : dist_t'(gap);
            return r;
        endfunction

        function void note_dates(date_pair_t p);
            owed_distances.push_back(predict_distance(p));
        endfunction

        function void check_result(dist_t got_distance, logic got_later);
            distance_t want;
            if (owed_distances.size() == 0) begin
                $error("unexpected transfer: day_distance %0d first_is_later %0b",
                       got_distance, got_later);
                failures++;
                return;
            end
            want = owed_distances.pop_front();
            if (got_distance !== want.day_distance) begin
                $error("day_distance: expected %0d, actual %0d",
                       want.day_distance, got_distance);
                failures++;
            end
            if (got_later !== want.first_is_later) begin
                $error("first_is_later: expected %0b, actual %0b",
                       want.first_is_later, got_later);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return owed_distances.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int unsigned cycle_count;

    gdd_in_if  dates_bus ();
    gdd_out_if result_bus ();

    distance_scoreboard board = new();
    date_pair_t         plan[$];

    gregorian_date_difference i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .dates  (dates_bus),
        .result (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic date_pair_t make_pair(int unsigned ya, int unsigned ma,
                                             int unsigned da, int unsigned yb,
                                             int unsigned mb, int unsigned db);
        date_pair_t p;
        p.year_a  = year_t'(ya);
        p.month_a = month_t'(ma);
        p.day_a   = day_t'(da);
        p.year_b  = year_t'(yb);
        p.month_b = month_t'(mb);
        p.day_b   = day_t'(db);
        return p;
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t  p;
        int unsigned pick;
        int unsigned ya;
        int unsigned ma;
        int unsigned yb;
        int unsigned mb;
        pick = $urandom_range(0, 99);
        ya = $urandom_range(1, 9999);
        ma = $urandom_range(1, 12);
        yb = $urandom_range(1, 9999);
        mb = $urandom_range(1, 12);
        if (pick >= 60 && pick < 80) begin
            yb = ya;
            if ($urandom_range(0, 1) == 1)
                yb = (ya < 9999) ? ya + 1 : ya - 1;
        end
        p = make_pair(ya, ma, $urandom_range(1, distance_scoreboard::month_days(ya, ma)),
                      yb, mb, $urandom_range(1, distance_scoreboard::month_days(yb, mb)));
        if (pick >= 80) begin
            p.year_a  = year_t'($urandom);
            p.month_a = month_t'($urandom);
            p.day_a   = day_t'($urandom);
            p.year_b  = year_t'($urandom);
            p.month_b = month_t'($urandom);
            p.day_b   = day_t'($urandom);
        end
        return p;
    endfunction

    task automatic send_dates(input date_pair_t p);
        dates_bus.valid   <= 1'b1;
        dates_bus.year_a  <= p.year_a;
        dates_bus.month_a <= p.month_a;
        dates_bus.day_a   <= p.day_a;
        dates_bus.year_b  <= p.year_b;
        dates_bus.month_b <= p.month_b;
        dates_bus.day_b   <= p.day_b;
        do
            @(posedge clk);
        while (!dates_bus.ready);
        board.note_dates(p);
    endtask

    task automatic hold_off(input int unsigned cycles);
        if (cycles > 0) begin
            dates_bus.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic run_plan();
        int unsigned burst_left;
        burst_left = $urandom_range(1, 16);
        foreach (plan[i])
        begin
            send_dates(plan[i]);
            burst_left--;
            if (burst_left == 0) begin
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 16);
            end
        end
        dates_bus.valid <= 1'b0;
        plan.delete();
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic plan_random(input int unsigned count);
        repeat (count) plan.push_back(random_pair());
    endtask

    initial
    begin : feed_dates
        rst_n              = 1'b0;
        dates_bus.valid   <= 1'b0;
        dates_bus.year_a  <= '0;
        dates_bus.month_a <= '0;
        dates_bus.day_a   <= '0;
        dates_bus.year_b  <= '0;
        dates_bus.month_b <= '0;
        dates_bus.day_b   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(make_pair(2000, 1, 1, 2000, 1, 1));
        plan.push_back(make_pair(1, 1, 1, 9999, 12, 31));
        plan.push_back(make_pair(9999, 12, 31, 1, 1, 1));
        plan.push_back(make_pair(2000, 2, 29, 2000, 3, 1));
        plan.push_back(make_pair(1900, 2, 28, 1900, 3, 1));
        plan.push_back(make_pair(2004, 3, 1, 2003, 3, 1));
        plan.push_back(make_pair(2100, 3, 1, 2100, 2, 28));
        plan.push_back(make_pair(0, 3, 1, 0, 2, 28));
        plan.push_back(make_pair(0, 0, 0, 16383, 15, 31));
        plan.push_back(make_pair(16383, 15, 31, 0, 0, 0));
        plan.push_back(make_pair(16383, 1, 1, 0, 1, 1));
        plan.push_back(make_pair(2023, 13, 5, 2023, 12, 5));
        plan.push_back(make_pair(2023, 14, 5, 2023, 15, 6));
        plan.push_back(make_pair(2023, 4, 31, 2023, 5, 1));
        plan.push_back(make_pair(2023, 3, 0, 2023, 2, 28));
        plan.push_back(make_pair(2024, 0, 15, 2024, 1, 15));
        plan.push_back(make_pair(12000, 6, 15, 9999, 6, 15));
        plan.push_back(make_pair(1, 1, 1, 1, 1, 2));
        plan.push_back(make_pair(1999, 12, 31, 2000, 1, 1));
        plan.push_back(make_pair(2400, 2, 29, 1600, 2, 29));
        plan.push_back(make_pair(5000, 14, 31, 5000, 2, 0));
        plan.push_back(make_pair(8191, 7, 16, 8192, 8, 15));
        run_plan();
        wait_drained();

        plan_random(RANDOM_ITEMS / 2);
        run_plan();
        wait_drained();

        plan_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        run_plan();
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (board.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : drain_results
        int unsigned mode;
        int unsigned mode_left;
        mode = 0;
        mode_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
                board.check_result(result_bus.day_distance, result_bus.first_is_later);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
                0:       result_bus.ready <= 1'b1;
                1:       result_bus.ready <= 1'($urandom_range(0, 1));
                2:       result_bus.ready <= ($urandom_range(0, 3) == 0);
                default: result_bus.ready <= 1'b0;
            endcase
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
